@@ hw/rtl/ssc_pkg.sv @@
// Shared types, constants and the commutation row table for six_step_commutation.
package ssc_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int DUTY_BITS  = 12;

  localparam int FIELD_W  = 16;
  localparam int DUTY_W   = DUTY_BITS + 1;
  localparam int VBUS_W   = FIELD_W - 1;
  localparam int SEC_W    = ANGLE_BITS + 3;
  localparam int IN_W     = 4 * FIELD_W;
  localparam int OUT_RAW  = 3 * DUTY_W + 4;
  localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8;
  localparam int CFG_W    = 16;
  localparam int CFG_AW   = 2;

  localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(1) << DUTY_BITS;
  localparam logic [DUTY_W-1:0] DUTY_HALF = DUTY_W'(1) << (DUTY_BITS - 1);

  // Register indexes on the config port
  localparam logic [CFG_AW-1:0] CFG_SECTOR_OFFSET  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_TORQUE_ADVANCE = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_MIN_BUS        = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_COAST_THR      = 2'd3;

  typedef enum logic [1:0] {
    PH_A = 2'd0,
    PH_B = 2'd1,
    PH_C = 2'd2
  } phase_t;

  typedef struct packed {
    logic   float_a;
    logic   float_b;
    logic   float_c;
    phase_t drive;
  } row_t;

  // Payload carried down the divider chain
  typedef struct packed {
    logic                 safe;
    logic                 sat;
    logic [2:0]           row;
    logic [VBUS_W-1:0]    divisor;
    logic [VBUS_W-1:0]    rem;
    logic [DUTY_BITS-1:0] quo;
  } div_pl_t;

  function automatic row_t row_lookup(input logic [2:0] row);
    row_t r;
    unique case (row)
      3'd0:    r = '{float_a: 1'b0, float_b: 1'b0, float_c: 1'b1, drive: PH_A};
      3'd1:    r = '{float_a: 1'b0, float_b: 1'b1, float_c: 1'b0, drive: PH_A};
      3'd2:    r = '{float_a: 1'b1, float_b: 1'b0, float_c: 1'b0, drive: PH_B};
      3'd3:    r = '{float_a: 1'b0, float_b: 1'b0, float_c: 1'b1, drive: PH_B};
      3'd4:    r = '{float_a: 1'b0, float_b: 1'b1, float_c: 1'b0, drive: PH_C};
      3'd5:    r = '{float_a: 1'b1, float_b: 1'b0, float_c: 1'b0, drive: PH_C};
      default: r = '{float_a: 1'b1, float_b: 1'b1, float_c: 1'b1, drive: PH_A};
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/six_step_commutation.sv @@
// Top level: six-step BLDC commutation pipeline with config registers.
// Registered path to out_tvalid: decode, each divider step (one quotient bit), output register.
// Throughput: one transfer per cycle while out_tready is high; the divider chain sets depth.
// Each stage holds only when the one after it is full and stalled, so bubbles are squeezed out.
// Reset (rst_n, synchronous, active low) empties the pipeline and loads the register defaults:
// sector_offset 3, torque_advance 2, min_bus_voltage 25, coast_current_threshold -10.
module six_step_commutation (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [15:0] target_current_q, [31:16] target_voltage_q, [47:32] bus_voltage,
  // [63:48] electrical_angle
  input  logic [ssc_pkg::IN_W-1:0]    in_tdata,
  // Result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [12:0] duty_a, [25:13] duty_b, [38:26] duty_c, [39] float_a, [40] float_b,
  // [41] float_c, [42] gate_enable, [47:43] zero
  output logic [ssc_pkg::OUT_W-1:0]   out_tdata,
  // Config write port
  input  logic                        cfg_we,
  input  logic [ssc_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [ssc_pkg::CFG_W-1:0]   cfg_wdata
);

  // Config registers
  logic [2:0]                       sector_offset_r;
  logic [2:0]                       torque_advance_r;
  logic [ssc_pkg::VBUS_W-1:0]       min_bus_voltage_r;
  logic [ssc_pkg::FIELD_W-1:0]      coast_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_offset_r   <= 3'd3;
      torque_advance_r  <= 3'd2;
      min_bus_voltage_r <= ssc_pkg::VBUS_W'(25);
      coast_thr_r       <= ssc_pkg::FIELD_W'(-10);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ssc_pkg::CFG_SECTOR_OFFSET:  sector_offset_r   <= cfg_wdata[2:0];
        ssc_pkg::CFG_TORQUE_ADVANCE: torque_advance_r  <= cfg_wdata[2:0];
        ssc_pkg::CFG_MIN_BUS:        min_bus_voltage_r <= cfg_wdata[ssc_pkg::VBUS_W-1:0];
        ssc_pkg::CFG_COAST_THR:      coast_thr_r       <= cfg_wdata[ssc_pkg::FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipe k+1 is the output of divider step g_div[k]; decode drives pipe 0.
  // rdy[k] is the consumer's ready for pipe k.
  ssc_pkg::div_pl_t pipe_data  [0:ssc_pkg::DUTY_BITS];
  logic             pipe_valid [0:ssc_pkg::DUTY_BITS];
  logic             rdy        [0:ssc_pkg::DUTY_BITS];

  ssc_decode u_decode (
    .clk             (clk),
    .rst_n           (rst_n),
    .valid_i         (in_tvalid),
    .data_i          (in_tdata),
    .ready_o         (in_tready),
    .sector_offset   (sector_offset_r),
    .torque_advance  (torque_advance_r),
    .min_bus_voltage (min_bus_voltage_r),
    .coast_thr       (coast_thr_r),
    .valid_o         (pipe_valid[0]),
    .data_o          (pipe_data[0]),
    .ready_i         (rdy[0])
  );

  // Restoring divider, MSB of the quotient first
  for (genvar k = 0; k < ssc_pkg::DUTY_BITS; k++) begin : g_div
    ssc_div_stage u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (pipe_valid[k]),
      .data_i  (pipe_data[k]),
      .ready_o (rdy[k]),
      .valid_o (pipe_valid[k+1]),
      .data_o  (pipe_data[k+1]),
      .ready_i (rdy[k+1])
    );
  end

  ssc_out u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (pipe_valid[ssc_pkg::DUTY_BITS]),
    .data_i  (pipe_data[ssc_pkg::DUTY_BITS]),
    .ready_o (rdy[ssc_pkg::DUTY_BITS]),
    .valid_o (out_tvalid),
    .data_o  (out_tdata),
    .ready_i (out_tready)
  );

  // Views of the result fields for the checks below
  logic [ssc_pkg::DUTY_W-1:0] chk_da, chk_db, chk_dc;
  logic [2:0]                 chk_float;
  logic                       chk_gate;

  assign chk_da    = out_tdata[ssc_pkg::DUTY_W-1:0];
  assign chk_db    = out_tdata[2*ssc_pkg::DUTY_W-1:ssc_pkg::DUTY_W];
  assign chk_dc    = out_tdata[3*ssc_pkg::DUTY_W-1:2*ssc_pkg::DUTY_W];
  assign chk_float = out_tdata[3*ssc_pkg::DUTY_W+2:3*ssc_pkg::DUTY_W];
  assign chk_gate  = out_tdata[3*ssc_pkg::DUTY_W+3];

  // Driving: exactly one phase floats
  a_one_float: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && chk_gate |-> $onehot(chk_float))
    else $error("active command without exactly one floating phase");

  // Driving: at most one phase carries duty
  a_one_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && chk_gate |-> $onehot0({chk_da != '0, chk_db != '0, chk_dc != '0}))
    else $error("more than one phase driven");

  // Coasting: all phases floated at half duty
  a_safe: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !chk_gate |-> chk_float == 3'b111 && chk_da == ssc_pkg::DUTY_HALF
      && chk_db == ssc_pkg::DUTY_HALF && chk_dc == ssc_pkg::DUTY_HALF)
    else $error("bad safe command");

  // Duty never exceeds full scale
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> chk_da <= ssc_pkg::DUTY_FULL && chk_db <= ssc_pkg::DUTY_FULL
      && chk_dc <= ssc_pkg::DUTY_FULL)
    else $error("duty above full scale");

endmodule

@@ hw/rtl/ssc_decode.sv @@
// Front stage: safe-output check, saturation check, sector row, divider setup.
module ssc_decode (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid_i,
  input  logic [ssc_pkg::IN_W-1:0]      data_i,
  output logic                          ready_o,
  input  logic [2:0]                    sector_offset,
  input  logic [2:0]                    torque_advance,
  input  logic [ssc_pkg::VBUS_W-1:0]    min_bus_voltage,
  input  logic [ssc_pkg::FIELD_W-1:0]   coast_thr,
  output logic                          valid_o,
  output ssc_pkg::div_pl_t              data_o,
  input  logic                          ready_i
);

  logic signed [ssc_pkg::FIELD_W-1:0] cur, vq, vbus, thr;
  logic [ssc_pkg::ANGLE_BITS-1:0]     ang;
  logic [ssc_pkg::SEC_W-1:0]          prod;
  logic [2:0]                         idx;
  logic [4:0]                         sum;
  ssc_pkg::div_pl_t                   pl_nxt, pl_r;
  logic                               valid_r;

  function automatic logic [2:0] mod6(input logic [4:0] v);
    logic [4:0] t;
    if (v >= 5'd18)      t = v - 5'd18;
    else if (v >= 5'd12) t = v - 5'd12;
    else if (v >= 5'd6)  t = v - 5'd6;
    else                 t = v;
    return t[2:0];
  endfunction

  always_comb begin
    cur  = signed'(data_i[ssc_pkg::FIELD_W-1:0]);
    vq   = signed'(data_i[2*ssc_pkg::FIELD_W-1:ssc_pkg::FIELD_W]);
    vbus = signed'(data_i[3*ssc_pkg::FIELD_W-1:2*ssc_pkg::FIELD_W]);
    ang  = ssc_pkg::ANGLE_BITS'(data_i[4*ssc_pkg::FIELD_W-1:3*ssc_pkg::FIELD_W]);
    thr  = signed'(coast_thr);

    // 6*angle + half a sector, top three bits give the shifted sector
    prod = (ssc_pkg::SEC_W'(ang) << 2) + (ssc_pkg::SEC_W'(ang) << 1)
         + (ssc_pkg::SEC_W'(1) << (ssc_pkg::ANGLE_BITS - 1));
    idx  = prod[ssc_pkg::SEC_W-1:ssc_pkg::ANGLE_BITS];
    if (idx == 3'd6) idx = 3'd0;
    sum  = {2'b00, idx} + {2'b00, torque_advance} + {2'b00, sector_offset};

    pl_nxt.safe    = (vbus <= signed'({1'b0, min_bus_voltage})) || (cur < thr) || vq[15];
    // Both operands non-negative whenever the result is not safe
    pl_nxt.sat     = (vq[ssc_pkg::VBUS_W-1:0] >= vbus[ssc_pkg::VBUS_W-1:0]);
    pl_nxt.row     = mod6(sum);
    pl_nxt.divisor = vbus[ssc_pkg::VBUS_W-1:0];
    pl_nxt.rem     = vq[ssc_pkg::VBUS_W-1:0];
    pl_nxt.quo     = '0;
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      pl_r <= pl_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = pl_r;

endmodule

@@ hw/rtl/ssc_div_stage.sv @@
// One restoring-division step: one quotient bit per stage.
module ssc_div_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid_i,
  input  ssc_pkg::div_pl_t data_i,
  output logic             ready_o,
  output logic             valid_o,
  output ssc_pkg::div_pl_t data_o,
  input  logic             ready_i
);

  logic [ssc_pkg::VBUS_W:0] shifted;
  logic [ssc_pkg::VBUS_W:0] diff;
  logic                     take;
  ssc_pkg::div_pl_t         pl_nxt, pl_r;
  logic                     valid_r;

  always_comb begin
    shifted = {data_i.rem, 1'b0};
    diff    = shifted - {1'b0, data_i.divisor};
    take    = (shifted >= {1'b0, data_i.divisor});
    pl_nxt     = data_i;
    pl_nxt.rem = take ? diff[ssc_pkg::VBUS_W-1:0] : shifted[ssc_pkg::VBUS_W-1:0];
    pl_nxt.quo = {data_i.quo[ssc_pkg::DUTY_BITS-2:0], take};
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      pl_r <= pl_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = pl_r;

endmodule

@@ hw/rtl/ssc_out.sv @@
// Output stage: phase routing from the row table and the output register.
module ssc_out (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      valid_i,
  input  ssc_pkg::div_pl_t          data_i,
  output logic                      ready_o,
  output logic                      valid_o,
  output logic [ssc_pkg::OUT_W-1:0] data_o,
  input  logic                      ready_i
);

  ssc_pkg::row_t              rt;
  logic [ssc_pkg::DUTY_W-1:0] duty, da, db, dc;
  logic                       fa, fb, fc, gate;
  logic [ssc_pkg::OUT_W-1:0]  out_nxt, out_r;
  logic                       valid_r;

  always_comb begin
    rt   = ssc_pkg::row_lookup(data_i.row);
    duty = data_i.sat ? ssc_pkg::DUTY_FULL : {1'b0, data_i.quo};
    if (data_i.safe) begin
      da   = ssc_pkg::DUTY_HALF;
      db   = ssc_pkg::DUTY_HALF;
      dc   = ssc_pkg::DUTY_HALF;
      fa   = 1'b1;
      fb   = 1'b1;
      fc   = 1'b1;
      gate = 1'b0;
    end else begin
      da   = (rt.drive == ssc_pkg::PH_A) ? duty : '0;
      db   = (rt.drive == ssc_pkg::PH_B) ? duty : '0;
      dc   = (rt.drive == ssc_pkg::PH_C) ? duty : '0;
      fa   = rt.float_a;
      fb   = rt.float_b;
      fc   = rt.float_c;
      gate = 1'b1;
    end
    out_nxt = ssc_pkg::OUT_W'({gate, fc, fb, fa, dc, db, da});
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      out_r <= out_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = out_r;

endmodule

@@ bench/tb_six_step_commutation.sv @@
// Self-checking stream testbench for the six-step commutation block.
`timescale 1ns / 100ps

module tb_six_step_commutation;

  // Input-to-output latency of the pipeline, and the overall run limit
  localparam int PIPE_LAT    = ssc_pkg::DUTY_BITS + 2;
  localparam int CYCLE_LIMIT = 500000;

  // One PWM request, packed as on in_tdata (last field in the lowest bits)
  typedef struct packed {
    logic [15:0]        angle;
    logic signed [15:0] vbus;
    logic signed [15:0] vq;
    logic signed [15:0] cur;
  } pwm_req_t;

  // One PWM command, packed as on out_tdata
  typedef struct packed {
    logic [ssc_pkg::OUT_W-ssc_pkg::OUT_RAW-1:0] pad;
    logic                                       gate;
    logic                                       flt_c;
    logic                                       flt_b;
    logic                                       flt_a;
    logic [ssc_pkg::DUTY_W-1:0]                 duty_c;
    logic [ssc_pkg::DUTY_W-1:0]                 duty_b;
    logic [ssc_pkg::DUTY_W-1:0]                 duty_a;
  } pwm_cmd_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  // [15:0] target_current_q, [31:16] target_voltage_q, [47:32] bus_voltage,
  // [63:48] electrical_angle
  logic [ssc_pkg::IN_W-1:0]     in_tdata;
  logic                         out_tvalid;
  logic                         out_tready;
  // [12:0] duty_a, [25:13] duty_b, [38:26] duty_c, [39] float_a, [40] float_b,
  // [41] float_c, [42] gate_enable, [47:43] zero
  logic [ssc_pkg::OUT_W-1:0]    out_tdata;
  logic                         cfg_we;
  logic [ssc_pkg::CFG_AW-1:0]   cfg_addr;
  logic [ssc_pkg::CFG_W-1:0]    cfg_wdata;

  // Shadow copies of the config registers, updated on every write
  logic [2:0]                   sh_offset;
  logic [2:0]                   sh_advance;
  logic [ssc_pkg::VBUS_W-1:0]   sh_min_bus;
  logic signed [15:0]           sh_coast_thr;

  pwm_cmd_t pending_cmds[$];   // expected commands, oldest first
  int       fail_cnt;
  int       cycle_cnt;
  int       tx_idle_pct;       // chance of a gap before each input transfer
  int       rx_idle_pct;       // chance of a receiver stall on a free cycle
  int       rx_hold_left;      // long receiver hold-off, in cycles
  int       rx_stall_left;

  six_step_commutation dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Run limit: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_six_step_commutation: FAIL");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Expected command for one request under the current shadow config.
  // Rows step the driven phase A, A, B, B, C, C and the floating phase
  // C, B, A, C, B, A.
  function automatic pwm_cmd_t predict_cmd(input pwm_req_t r);
    pwm_cmd_t         c;
    longint           quot;
    int               sect;
    int               row;
    ssc_pkg::phase_t  drive;
    ssc_pkg::phase_t  flt;
    c = '0;
    // Coast: bus at or under the floor, braking current, or negative voltage
    if (int'(r.vbus) <= int'(sh_min_bus) || int'(r.cur) < int'(sh_coast_thr) ||
        int'(r.vq) < 0) begin
      c.duty_a = ssc_pkg::DUTY_HALF;
      c.duty_b = ssc_pkg::DUTY_HALF;
      c.duty_c = ssc_pkg::DUTY_HALF;
      c.flt_a  = 1'b1;
      c.flt_b  = 1'b1;
      c.flt_c  = 1'b1;
      c.gate   = 1'b0;
      return c;
    end
    // vbus >= 1 here; duty is the floored ratio, capped at full scale
    quot = (longint'(r.vq) * (longint'(1) << ssc_pkg::DUTY_BITS)) / longint'(r.vbus);
    if (quot > longint'(ssc_pkg::DUTY_FULL))
      quot = longint'(ssc_pkg::DUTY_FULL);
    // Sector from the angle shifted by 1/12 turn, then advance and routing shift
    sect  = ((6 * int'(r.angle) + (1 << (ssc_pkg::ANGLE_BITS - 1)))
             >> ssc_pkg::ANGLE_BITS) % 6;
    row   = (sect + int'(sh_advance) + int'(sh_offset)) % 6;
    drive = ssc_pkg::phase_t'(row / 2);
    flt   = ssc_pkg::phase_t'(2 - row % 3);
    case (drive)
      ssc_pkg::PH_A: c.duty_a = quot[ssc_pkg::DUTY_W-1:0];
      ssc_pkg::PH_B: c.duty_b = quot[ssc_pkg::DUTY_W-1:0];
      default:       c.duty_c = quot[ssc_pkg::DUTY_W-1:0];
    endcase
    c.flt_a = (flt == ssc_pkg::PH_A);
    c.flt_b = (flt == ssc_pkg::PH_B);
    c.flt_c = (flt == ssc_pkg::PH_C);
    c.gate  = 1'b1;
    return c;
  endfunction

  function automatic pwm_req_t mk_req(input int cur, input int vq, input int vbus,
                                      input int angle);
    pwm_req_t r;
    r.cur   = 16'(cur);
    r.vq    = 16'(vq);
    r.vbus  = 16'(vbus);
    r.angle = 16'(angle);
    return r;
  endfunction

  // Random request: mostly ones that pass the coast checks, some that just
  // miss them, the rest pure noise over all 64 bits
  function automatic pwm_req_t rand_req();
    pwm_req_t r;
    int       kind;
    int       lo;
    r    = pwm_req_t'({$urandom, $urandom});
    kind = $urandom_range(0, 9);
    if (kind <= 6 && sh_min_bus != {ssc_pkg::VBUS_W{1'b1}}) begin
      r.vbus = 16'(int'(sh_min_bus) + 1 + $urandom_range(0, 32766 - int'(sh_min_bus)));
      lo     = int'(sh_coast_thr);
      r.cur  = 16'(lo + $urandom_range(0, 32767 - lo));
      if ($urandom_range(0, 1))
        r.vq = 16'($urandom_range(0, int'(r.vbus)));
      else
        r.vq = 16'($urandom_range(0, 32767));
    end else if (kind == 7) begin
      case ($urandom_range(0, 2))
        0:       r.vbus = 16'(int'(sh_min_bus) - int'($urandom_range(0, 3)));
        1:       r.cur  = 16'(int'(sh_coast_thr) - 1 - int'($urandom_range(0, 3)));
        default: r.vq   = 16'(-1 - int'($urandom_range(0, 3)));
      endcase
    end
    return r;
  endfunction

  // Drive one request; the expectation is queued at the transfer edge
  task automatic send_req(input pwm_req_t r);
    int gap;
    gap = ($urandom_range(0, 99) < tx_idle_pct) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = r;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_cmds.push_back(predict_cmd(r));
  endtask

  // Stop offering, wait for every pending command, then let the pipe empty
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ssc_pkg::CFG_AW-1:0] idx,
                           input logic [ssc_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(posedge clk);
    case (idx)
      ssc_pkg::CFG_SECTOR_OFFSET:  sh_offset    = val[2:0];
      ssc_pkg::CFG_TORQUE_ADVANCE: sh_advance   = val[2:0];
      ssc_pkg::CFG_MIN_BUS:        sh_min_bus   = val[ssc_pkg::VBUS_W-1:0];
      default:                     sh_coast_thr = val;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Receiver: long hold-off when asked, otherwise random stalls
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        out_tready = 1'b0;
        rx_hold_left--;
      end else if (rx_stall_left > 0) begin
        out_tready = 1'b0;
        rx_stall_left--;
      end else if ($urandom_range(0, 99) < rx_idle_pct) begin
        out_tready    = 1'b0;
        rx_stall_left = pick_gap() - 1;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Result checker: every output transfer against the oldest expectation
  always @(posedge clk) begin : check_results
    pwm_cmd_t got;
    pwm_cmd_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_cmds.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result %h with nothing pending", got);
      end else begin
        want = pending_cmds.pop_front();
        if (got.duty_a !== want.duty_a || got.duty_b !== want.duty_b ||
            got.duty_c !== want.duty_c || got.flt_a !== want.flt_a ||
            got.flt_b !== want.flt_b || got.flt_c !== want.flt_c ||
            got.gate !== want.gate || got.pad !== want.pad) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("mismatch: exp duty %0d/%0d/%0d float %b%b%b gate %b pad %h",
                     want.duty_a, want.duty_b, want.duty_c, want.flt_a, want.flt_b,
                     want.flt_c, want.gate, want.pad);
            $display("          got duty %0d/%0d/%0d float %b%b%b gate %b pad %h",
                     got.duty_a, got.duty_b, got.duty_c, got.flt_a, got.flt_b,
                     got.flt_c, got.gate, got.pad);
          end
        end
      end
    end
  end

  // Reset config: coast boundaries, duty extremes and every sector
  task automatic test_directed_edges();
    int k;
    tx_idle_pct = 30;
    rx_idle_pct = 30;
    send_req(mk_req(0, 100, 25, 0));            // bus exactly at the floor: coast
    send_req(mk_req(0, 26, 26, 0));             // Vq == Vbus: full duty
    send_req(mk_req(0, 25, 26, 100));           // fraction, floored
    send_req(mk_req(0, 32767, 26, 0));          // ratio far above 1: saturates
    send_req(mk_req(0, 32767, 32767, 65535));   // largest values, top angle
    send_req(mk_req(0, 0, 1000, 30000));        // zero voltage: zero duty
    send_req(mk_req(0, -1, 1000, 0));           // negative voltage: coast
    send_req(mk_req(0, -32768, 1000, 0));
    send_req(mk_req(-10, 500, 1000, 0));        // current at threshold: drives
    send_req(mk_req(-11, 500, 1000, 0));        // just below: coast
    send_req(mk_req(-32768, 500, 1000, 0));
    send_req(mk_req(32767, 500, 1000, 0));
    send_req(mk_req(0, 500, -1, 0));            // negative bus: coast
    send_req(mk_req(0, 500, -32768, 0));
    send_req(mk_req(0, 500, 0, 0));
    send_req(mk_req(0, 500, 1000, 5461));       // last angle of the first sector
    send_req(mk_req(0, 500, 1000, 5462));       // first angle of the next
    for (k = 1; k < 6; k++)
      send_req(mk_req(k * 1000, 200 * k, 1500, k * 10923));
    send_req(mk_req(-1, -1, -1, 65535));        // all ones
    settle();
  endtask

  // Several register settings, extremes and out-of-range shifts among them
  task automatic test_config_sweep();
    int unsigned offs[8] = '{0, 5, 0, 5, 7, 1, 2, 6};
    int unsigned advs[8] = '{0, 5, 5, 0, 6, 4, 3, 7};
    int unsigned mins[8] = '{0, 32767, 1000, 25, 3, 12000, 0, 25};
    int          thrs[8] = '{-32768, 0, -1, -10, -200, -32768, 0, -10};
    int          p;
    int          n;
    for (p = 0; p < 8; p++) begin
      write_reg(ssc_pkg::CFG_SECTOR_OFFSET, ssc_pkg::CFG_W'(offs[p]));
      write_reg(ssc_pkg::CFG_TORQUE_ADVANCE, ssc_pkg::CFG_W'(advs[p]));
      write_reg(ssc_pkg::CFG_MIN_BUS, ssc_pkg::CFG_W'(mins[p]));
      write_reg(ssc_pkg::CFG_COAST_THR, ssc_pkg::CFG_W'(thrs[p]));
      tx_idle_pct = (p % 2) ? 25 : 0;
      rx_idle_pct = (p % 3) ? 25 : 0;
      for (n = 0; n < 80; n++)
        send_req(rand_req());
      settle();
    end
  endtask

  // Bulk random traffic: a stretch at full rate, then idling on both sides
  task automatic test_random_traffic();
    int n;
    write_reg(ssc_pkg::CFG_SECTOR_OFFSET, 16'd3);
    write_reg(ssc_pkg::CFG_TORQUE_ADVANCE, 16'd2);
    write_reg(ssc_pkg::CFG_MIN_BUS, 16'd25);
    write_reg(ssc_pkg::CFG_COAST_THR, 16'hFFF6);
    for (n = 0; n < 300; n++) begin
      tx_idle_pct = (n < 100) ? 0 : 35;
      rx_idle_pct = (n < 100) ? 0 : 35;
      send_req(rand_req());
    end
    settle();
  endtask

  // Receiver holds off long enough for the pipe to fill and stall the input
  task automatic test_rx_backpressure();
    int n;
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    rx_hold_left = 4 * PIPE_LAT + 40;
    for (n = 0; n < 80; n++)
      send_req(rand_req());
    settle();
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    fail_cnt      = 0;
    cycle_cnt     = 0;
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    rx_hold_left  = 0;
    rx_stall_left = 0;
    // Register values after reset
    sh_offset     = 3'd3;
    sh_advance    = 3'd2;
    sh_min_bus    = ssc_pkg::VBUS_W'(25);
    sh_coast_thr  = -16'sd10;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_edges();
    test_config_sweep();
    test_random_traffic();
    test_rx_backpressure();

    // Anything arriving now would be a stray result
    repeat (2 * PIPE_LAT) @(posedge clk);
    if (fail_cnt == 0 && pending_cmds.size() == 0)
      $display("tb_six_step_commutation: PASS");
    else
      $display("tb_six_step_commutation: FAIL");
    $finish;
  end

endmodule
